// ===== rtl/csvf_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV formatter package
// Shared constants, codes and types for the decimal CSV line formatter.
// ----------------------------------------------------------------------------
package csvf_pkg;

   // ASCII characters of the line.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   // Widths of the converter.
   localparam int BIN_WIDTH  = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
   localparam int CNT_WIDTH  = $clog2(BIN_WIDTH + 1);
   localparam int IDX_WIDTH  = $clog2(BCD_DIGITS);

   // Field codes, in line order.
   localparam logic [1:0] FIELD_SAMPLE  = 2'd0;
   localparam logic [1:0] FIELD_PERCENT = 2'd1;
   localparam logic [1:0] FIELD_RATE    = 2'd2;
   localparam logic [1:0] FIELD_RAW     = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CONV,
      ST_DIGIT,
      ST_SEP,
      ST_LF
   } seq_state_type;

   // Command to the shared converter.
   typedef struct packed {
      logic                 start;
      logic [BIN_WIDTH-1:0] value;
      logic [CNT_WIDTH-1:0] nbits;
   } conv_ctrl_type;

   // Status from the shared converter.
   typedef struct packed {
      logic                 done;
      logic [BCD_WIDTH-1:0] bcd;
   } conv_stat_type;

endpackage

// ===== rtl/csvf_req_if.sv =====
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel that carries one record of four unsigned values.
// ----------------------------------------------------------------------------
interface csvf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_value;
   logic [7:0]  percent_value;
   logic [15:0] rate_value;
   logic [31:0] raw_reading;

   modport source (
      output valid, sample_value, percent_value, rate_value, raw_reading,
      input  ready
   );
   modport sink (
      input  valid, sample_value, percent_value, rate_value, raw_reading,
      output ready
   );
endinterface

// ===== rtl/csvf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Text byte channel
// Valid/ready channel that carries one ASCII byte of the line and its end flag.
// ----------------------------------------------------------------------------
interface csvf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       line_end;

   modport source (
      output valid, text_byte, line_end,
      input  ready
   );
   modport sink (
      input  valid, text_byte, line_end,
      output ready
   );
endinterface

// ===== rtl/csvf_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// Binary to BCD converter
// Shift-and-add-3 unit that converts one left-aligned value, one bit a cycle.
// ----------------------------------------------------------------------------
module csvf_bcd_conv (
   input  logic                    clock,
   input  logic                    reset,
   input  csvf_pkg::conv_ctrl_type ctrl,
   output csvf_pkg::conv_stat_type stat
);

   logic                                busy_ff,  busy_in;
   logic                                done_ff,  done_in;
   logic [csvf_pkg::CNT_WIDTH-1:0]      cnt_ff,   cnt_in;
   logic [csvf_pkg::BIN_WIDTH-1:0]      bin_ff,   bin_in;
   logic [csvf_pkg::BCD_WIDTH-1:0]      bcd_ff,   bcd_in;
   logic [csvf_pkg::BCD_WIDTH-1:0]      bcd_adj;

   // Add three to every digit that is five or more before the shift.
   always_comb begin
      logic [3:0] nib;
      nib     = 4'h0;
      bcd_adj = bcd_ff;
      for (int i = 0; i < csvf_pkg::BCD_DIGITS; i++) begin
         nib = bcd_ff[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? 4'(nib + 4'd3) : nib;
      end
   end

   // Load on start, then shift one binary bit into the digits per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctrl.nbits;
         bin_in  = ctrl.value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bcd_in  = {bcd_adj[csvf_pkg::BCD_WIDTH-2:0], bin_ff[csvf_pkg::BIN_WIDTH-1]};
         bin_in  = {bin_ff[csvf_pkg::BIN_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != 1);
         done_in = (cnt_ff == 1);
      end
   end

   // Control state is reset; the data path is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.done = done_ff;
   assign stat.bcd  = bcd_ff;

endmodule

// ===== rtl/csvf_sequencer.sv =====
// ----------------------------------------------------------------------------
// Line sequencer
// Steps through the four fields, drives the converter and emits the bytes.
// ----------------------------------------------------------------------------
module csvf_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   csvf_req_if.sink                req_chan,
   csvf_rsp_if.source              rsp_chan,
   output csvf_pkg::conv_ctrl_type ctrl,
   input  csvf_pkg::conv_stat_type stat
);

   csvf_pkg::seq_state_type            state_ff, state_in;
   logic [1:0]                         field_ff, field_in;
   logic [csvf_pkg::IDX_WIDTH-1:0]     idx_ff,   idx_in;
   logic                               started_ff, started_in;
   logic [15:0]                        sample_ff,  sample_in;
   logic [7:0]                         percent_ff, percent_in;
   logic [15:0]                        rate_ff,    rate_in;
   logic [31:0]                        raw_ff,     raw_in;
   logic                               out_valid_ff, out_valid_in;
   logic [7:0]                         out_byte_ff,  out_byte_in;
   logic                               out_last_ff,  out_last_in;

   logic                               accept;
   logic                               out_free;
   logic [3:0]                         digit;
   logic                               skip_zero;
   logic                               last_digit;

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign digit      = stat.bcd[idx_ff*4 +: 4];
   assign skip_zero  = !started_ff && (digit == 4'h0) && (idx_ff != '0);
   assign last_digit = (idx_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csvf_pkg::ST_IDLE: begin
            if (accept) state_in = csvf_pkg::ST_LOAD;
         end
         csvf_pkg::ST_LOAD: begin
            state_in = csvf_pkg::ST_CONV;
         end
         csvf_pkg::ST_CONV: begin
            if (stat.done) state_in = csvf_pkg::ST_DIGIT;
         end
         csvf_pkg::ST_DIGIT: begin
            if (!skip_zero && out_free && last_digit) state_in = csvf_pkg::ST_SEP;
         end
         csvf_pkg::ST_SEP: begin
            if (out_free) begin
               state_in = (field_ff == csvf_pkg::FIELD_RAW) ? csvf_pkg::ST_LF
                                                            : csvf_pkg::ST_LOAD;
            end
         end
         csvf_pkg::ST_LF: begin
            if (out_free) state_in = csvf_pkg::ST_IDLE;
         end
         default: state_in = csvf_pkg::ST_IDLE;
      endcase
   end

   // Converter command: the current field, left-aligned, with its bit count.
   always_comb begin
      ctrl.start = (state_ff == csvf_pkg::ST_LOAD);
      unique case (field_ff)
         csvf_pkg::FIELD_SAMPLE: begin
            ctrl.value = {sample_ff, 16'h0000};
            ctrl.nbits = csvf_pkg::CNT_WIDTH'(16);
         end
         csvf_pkg::FIELD_PERCENT: begin
            ctrl.value = {percent_ff, 24'h000000};
            ctrl.nbits = csvf_pkg::CNT_WIDTH'(8);
         end
         csvf_pkg::FIELD_RATE: begin
            ctrl.value = {rate_ff, 16'h0000};
            ctrl.nbits = csvf_pkg::CNT_WIDTH'(16);
         end
         default: begin
            ctrl.value = raw_ff;
            ctrl.nbits = csvf_pkg::CNT_WIDTH'(32);
         end
      endcase
   end

   // Outputs and data registers.
   always_comb begin
      field_in     = field_ff;
      idx_in       = idx_ff;
      started_in   = started_ff;
      sample_in    = sample_ff;
      percent_in   = percent_ff;
      rate_in      = rate_ff;
      raw_in       = raw_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         csvf_pkg::ST_IDLE: begin
            if (accept) begin
               field_in   = csvf_pkg::FIELD_SAMPLE;
               sample_in  = req_chan.sample_value;
               percent_in = req_chan.percent_value;
               rate_in    = req_chan.rate_value;
               raw_in     = req_chan.raw_reading;
            end
         end
         csvf_pkg::ST_LOAD: begin
         end
         csvf_pkg::ST_CONV: begin
            // Start at the highest digit the field can hold.
            started_in = 1'b0;
            unique case (field_ff)
               csvf_pkg::FIELD_PERCENT: idx_in = csvf_pkg::IDX_WIDTH'(2);
               csvf_pkg::FIELD_RAW:     idx_in = csvf_pkg::IDX_WIDTH'(9);
               default:                 idx_in = csvf_pkg::IDX_WIDTH'(4);
            endcase
         end
         csvf_pkg::ST_DIGIT: begin
            if (skip_zero) begin
               idx_in = idx_ff - 1'b1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = 8'(csvf_pkg::CHAR_ZERO + {4'h0, digit});
               out_last_in  = 1'b0;
               started_in   = 1'b1;
               if (!last_digit) idx_in = idx_ff - 1'b1;
            end
         end
         csvf_pkg::ST_SEP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               if (field_ff == csvf_pkg::FIELD_RAW) begin
                  out_byte_in = csvf_pkg::CHAR_CR;
               end else begin
                  out_byte_in = csvf_pkg::CHAR_COMMA;
                  field_in    = field_ff + 1'b1;
               end
            end
         end
         csvf_pkg::ST_LF: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = csvf_pkg::CHAR_LF;
               out_last_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csvf_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      field_ff    <= field_in;
      idx_ff      <= idx_in;
      started_ff  <= started_in;
      sample_ff   <= sample_in;
      percent_ff  <= percent_in;
      rate_ff     <= rate_in;
      raw_ff      <= raw_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign req_chan.ready     = (state_ff == csvf_pkg::ST_IDLE);
   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.text_byte = out_byte_ff;
   assign rsp_chan.line_end  = out_last_ff;

endmodule

// ===== rtl/csv_decimal_frame_formatter.sv =====
// ----------------------------------------------------------------------------
// Decimal CSV line formatter
// Formats a record of four unsigned values as one ASCII line, one byte a transfer.
// ----------------------------------------------------------------------------
// A new record is accepted only in the idle state, once the last byte of the
// previous line has been issued. The pace is set by the shift-and-add-3
// converter (one bit a cycle, 72 bits) and one digit slot a cycle while the output
// is free; output stalls hold the sequencer. Reset clears the sequencer and the
// output valid at once; no clearing pass is needed.
module csv_decimal_frame_formatter (
   input  logic        clock,
   input  logic        reset,
   csvf_req_if.sink    req_chan,
   csvf_rsp_if.source  rsp_chan
);

   csvf_pkg::conv_ctrl_type conv_ctrl;
   csvf_pkg::conv_stat_type conv_stat;

   // Field sequencing and byte output.
   csvf_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .ctrl     (conv_ctrl),
      .stat     (conv_stat)
   );

   // Shared binary to decimal unit.
   csvf_bcd_conv u_bcd_conv (
      .clock (clock),
      .reset (reset),
      .ctrl  (conv_ctrl),
      .stat  (conv_stat)
   );

endmodule

// ===== test/tb_csv_decimal_frame_formatter.sv =====
// ----------------------------------------------------------------------------
// Decimal CSV line formatter testbench
// Sends records of four unsigned values and checks every text byte of the
// resulting ASCII line against a line predicted inside the testbench. Both
// channels idle at random, the sink holds off once for a long stretch so the
// block backs up, and the sender once waits for the line buffer to drain.
// ----------------------------------------------------------------------------
module tb_csv_decimal_frame_formatter;

   // One predicted byte of a text line.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
   } line_char_type;

   // Predicts the text line of each accepted record and checks the bytes.
   class line_checker;
      line_char_type expected_q[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void push_char(logic [7:0] text, logic last);
         line_char_type item;
         item.text_byte = text;
         item.line_end  = last;
         expected_q.push_back(item);
      endfunction

      // Decimal digits, most significant first, no leading zeros.
      function void push_decimal(logic [31:0] value);
         logic [7:0]  digits [10];
         int          n;
         logic [31:0] rest;
         rest = value;
         n    = 0;
         do begin
            digits[n] = csvf_pkg::CHAR_ZERO + 8'(rest % 32'd10);
            n++;
            rest = rest / 32'd10;
         end while (rest != 0);
         while (n > 0) begin
            n--;
            push_char(digits[n], 1'b0);
         end
      endfunction

      function void note_record(logic [15:0] sample, logic [7:0] percent,
                                logic [15:0] rate, logic [31:0] raw);
         push_decimal({16'd0, sample});
         push_char(csvf_pkg::CHAR_COMMA, 1'b0);
         push_decimal({24'd0, percent});
         push_char(csvf_pkg::CHAR_COMMA, 1'b0);
         push_decimal({16'd0, rate});
         push_char(csvf_pkg::CHAR_COMMA, 1'b0);
         push_decimal(raw);
         push_char(csvf_pkg::CHAR_CR, 1'b0);
         push_char(csvf_pkg::CHAR_LF, 1'b1);
      endfunction

      function void check_byte(logic [7:0] text, logic last);
         line_char_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected text byte %h with line_end %b", text, last);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (text !== want.text_byte) begin
            $error("text_byte: expected %h, actual %h", want.text_byte, text);
            errors++;
         end
         if (last !== want.line_end) begin
            $error("line_end: expected %b, actual %b", want.line_end, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        steady = 1'b0;
   logic        long_hold_req = 1'b0;
   line_checker lines = new();

   csvf_req_if req_bus ();
   csvf_rsp_if rsp_bus ();

   csv_decimal_frame_formatter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Clock with a period of 4.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #2000000;
      $display("tb_csv_decimal_frame_formatter NOT OK");
      $finish;
   end

   // Random field value, often cut to fewer bits so that all digit counts occur.
   function automatic logic [31:0] rand_field(int width);
      logic [31:0] value;
      int          keep;
      value = $urandom;
      if ($urandom_range(3) != 0) keep = $urandom_range(width, 1);
      else keep = width;
      return value & 32'((33'd1 << keep) - 33'd1);
   endfunction

   // Offers one record until it is transferred, then maybe idles a while.
   task automatic send_record(logic [15:0] sample, logic [7:0] percent,
                              logic [15:0] rate, logic [31:0] raw);
      req_bus.valid         <= 1'b1;
      req_bus.sample_value  <= sample;
      req_bus.percent_value <= percent;
      req_bus.rate_value    <= rate;
      req_bus.raw_reading   <= raw;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      lines.note_record(sample, percent, rate, raw);
      if (!steady && $urandom_range(99) < 15) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // Sink side: checks each transfer and chooses ready for the next cycle.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            lines.check_byte(rsp_bus.text_byte, rsp_bus.line_end);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 15);
         end
      end
   end

   // Source side and end of run.
   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.sample_value  <= '0;
      req_bus.percent_value <= '0;
      req_bus.rate_value    <= '0;
      req_bus.raw_reading   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zeros, full-scale values and the edges where a digit is added.
      send_record(16'd0, 8'd0, 16'd0, 32'd0);
      send_record(16'd65535, 8'd255, 16'd65535, 32'hFFFF_FFFF);
      send_record(16'd9, 8'd9, 16'd9, 32'd9);
      send_record(16'd10, 8'd10, 16'd10, 32'd10);
      send_record(16'd99, 8'd99, 16'd99, 32'd99);
      send_record(16'd100, 8'd100, 16'd100, 32'd100);
      send_record(16'd999, 8'd1, 16'd999, 32'd999_999_999);
      send_record(16'd1000, 8'd0, 16'd1000, 32'd1_000_000_000);
      send_record(16'd9999, 8'd200, 16'd9999, 32'd99_999);
      send_record(16'd10000, 8'd128, 16'd10000, 32'd100_000);
      send_record(16'd1, 8'd1, 16'd1, 32'd1);
      send_record(16'd32768, 8'd64, 16'd0, 32'h8000_0000);
      send_record(16'd0, 8'd255, 16'd65535, 32'd0);
      send_record(16'd60, 8'd98, 16'd72, 32'd123_456);

      // Random records with a long hold on the sink and one full drain.
      for (int i = 0; i < 100; i++) begin
         if (i == 20) long_hold_req = 1'b1;
         if (i == 75) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (lines.pending() != 0) @(posedge clock);
         end
         steady = (i >= 40 && i < 65);
         send_record(16'(rand_field(16)), 8'(rand_field(8)), 16'(rand_field(16)),
                     rand_field(32));
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (lines.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (lines.pending() != 0) begin
         $error("%0d text bytes never arrived", lines.pending());
         lines.errors++;
      end
      if (lines.errors == 0) $display("tb_csv_decimal_frame_formatter OK");
      else $display("tb_csv_decimal_frame_formatter NOT OK");
      $finish;
   end
endmodule
